// ===== hw/rtl/cncb_pkg.sv =====
// ----------------------------------------------------------------------------
// cncb_pkg
// Shared types, constants and helpers for the card number check and brand
// unit: the record passed from the front end to the back end, queue status
// and the brand rule table.
// ----------------------------------------------------------------------------
package cncb_pkg;

    // Character and length limits
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [4:0] COUNT_MAX = 5'd31;
    localparam logic [4:0] MIN_LEN   = 5'd13;
    localparam logic [4:0] MAX_LEN   = 5'd19;
    localparam logic [4:0] PFX_LEN   = 5'd6;

    // Queue geometry (depth is a power of two so the pointers wrap by themselves)
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    // Brand codes, tried in this order
    typedef logic [3:0] t_brand;
    localparam t_brand BRAND_NONE  = 4'd0;
    localparam t_brand BRAND_LEAD4 = 4'd1;  // leading 4, 13..16 digits
    localparam t_brand BRAND_51_55 = 4'd2;  // 51..55 or 2221..2720, 16 digits
    localparam t_brand BRAND_34_37 = 4'd3;  // 34 or 37, 15 digits
    localparam t_brand BRAND_62    = 4'd4;  // 62, 16..19 digits
    localparam t_brand BRAND_6011  = 4'd5;  // 6011, 65 or 622126..622925, 16 digits
    localparam t_brand BRAND_35    = 4'd6;  // 3528..3589, 16 digits
    localparam t_brand BRAND_30_39 = 4'd7;  // 300..305, 36, 38, 39, 14 digits
    localparam t_brand BRAND_5_6X  = 4'd8;  // 50 or 56..69, 12..19 digits

    // Summary of one finished number, front end to back end
    typedef struct packed {
        logic [4:0]  count;
        logic        luhn_zero;
        logic        all_equal;
        logic [3:0]  p1;
        logic [6:0]  p2;
        logic [9:0]  p3;
        logic [13:0] p4;
        logic [19:0] p6;
    } t_rec;

    // Queue status seen by both ends
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Luhn doubling of one digit
    function automatic logic [3:0] luhn_dbl(input logic [3:0] d);
        logic [4:0] t;
        t = {d, 1'b0};
        return (t > 5'd9) ? 4'(t - 5'd9) : t[3:0];
    endfunction

    // Add a digit to a running sum modulo ten (both operands below ten)
    function automatic logic [3:0] mod10_add(input logic [3:0] s, input logic [3:0] a);
        logic [4:0] t;
        t = {1'b0, s} + {1'b0, a};
        return (t >= 5'd10) ? 4'(t - 5'd10) : t[3:0];
    endfunction

    // Brand from length and prefixes; first matching rule wins
    function automatic t_brand brand_of(input logic [4:0]  len,
                                        input logic [3:0]  p1,
                                        input logic [6:0]  p2,
                                        input logic [9:0]  p3,
                                        input logic [13:0] p4,
                                        input logic [19:0] p6);
        t_brand b;
        b = BRAND_NONE;
        if (p1 == 4'd4 && len >= 5'd13 && len <= 5'd16) begin
            b = BRAND_LEAD4;
        end else if (len == 5'd16 && ((p2 >= 7'd51 && p2 <= 7'd55) ||
                                      (p4 >= 14'd2221 && p4 <= 14'd2720))) begin
            b = BRAND_51_55;
        end else if (len == 5'd15 && (p2 == 7'd34 || p2 == 7'd37)) begin
            b = BRAND_34_37;
        end else if (p2 == 7'd62 && len >= 5'd16 && len <= 5'd19) begin
            b = BRAND_62;
        end else if (len == 5'd16 && (p4 == 14'd6011 || p2 == 7'd65 ||
                                      (p6 >= 20'd622126 && p6 <= 20'd622925))) begin
            b = BRAND_6011;
        end else if (len == 5'd16 && p4 >= 14'd3528 && p4 <= 14'd3589) begin
            b = BRAND_35;
        end else if (len == 5'd14 && ((p3 >= 10'd300 && p3 <= 10'd305) ||
                                      p2 == 7'd36 || p2 == 7'd38 || p2 == 7'd39)) begin
            b = BRAND_30_39;
        end else if (len >= 5'd12 && len <= 5'd19 &&
                     (p2 == 7'd50 || (p2 >= 7'd56 && p2 <= 7'd69))) begin
            b = BRAND_5_6X;
        end
        return b;
    endfunction

endpackage

// ===== hw/rtl/cncb_front.sv =====
// ----------------------------------------------------------------------------
// cncb_front
// Accepts characters, drops non-digits and keeps the running count, the two
// Luhn sums, the equal-digit flag and the prefixes; pushes one summary
// record into the queue on the last character and clears its state.
// ----------------------------------------------------------------------------
module cncb_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [7:0]       i_char,
    input  logic             i_last,
    input  cncb_pkg::t_q_stat i_q_stat,
    output logic             o_push,
    output cncb_pkg::t_rec   o_rec
);
    import cncb_pkg::*;

    logic [4:0]  r_count, n_count, upd_count;
    logic [3:0]  r_sum_e, n_sum_e, upd_sum_e;
    logic [3:0]  r_sum_o, n_sum_o, upd_sum_o;
    logic [3:0]  r_lead,  n_lead,  upd_lead;
    logic        r_equal, n_equal, upd_equal;
    logic [19:0] r_pfx,   upd_pfx;
    logic [6:0]  r_p2,    upd_p2;
    logic [9:0]  r_p3,    upd_p3;
    logic [13:0] r_p4,    upd_p4;

    logic       accept;
    logic       is_digit;
    logic [3:0] digit;
    logic [3:0] dbl;
    logic [3:0] sel_sum;

    assign o_ready  = !i_q_stat.full;
    assign accept   = i_valid && o_ready;
    assign is_digit = (i_char >= CHAR_ZERO) && (i_char <= CHAR_NINE);
    assign digit    = i_char[3:0];
    assign dbl      = luhn_dbl(digit);

    // Fold the current digit into the running state
    always_comb begin
        upd_count = r_count;
        upd_sum_e = r_sum_e;
        upd_sum_o = r_sum_o;
        upd_lead  = r_lead;
        upd_equal = r_equal;
        upd_pfx   = r_pfx;
        upd_p2    = r_p2;
        upd_p3    = r_p3;
        upd_p4    = r_p4;
        if (accept && is_digit) begin
            if (!r_count[0]) begin
                upd_sum_e = mod10_add(r_sum_e, dbl);
                upd_sum_o = mod10_add(r_sum_o, digit);
            end else begin
                upd_sum_e = mod10_add(r_sum_e, digit);
                upd_sum_o = mod10_add(r_sum_o, dbl);
            end
            if (r_count == 5'd0) begin
                upd_lead = digit;
            end else if (digit != r_lead) begin
                upd_equal = 1'b0;
            end
            if (r_count < PFX_LEN) begin
                upd_pfx = 20'(r_pfx * 20'd10 + 20'(digit));
            end
            if (r_count == 5'd1) begin
                upd_p2 = upd_pfx[6:0];
            end
            if (r_count == 5'd2) begin
                upd_p3 = upd_pfx[9:0];
            end
            if (r_count == 5'd3) begin
                upd_p4 = upd_pfx[13:0];
            end
            if (r_count != COUNT_MAX) begin
                upd_count = r_count + 5'd1;
            end
        end
    end

    // Build the record from the state including the last character
    assign sel_sum = upd_count[0] ? upd_sum_o : upd_sum_e;

    always_comb begin
        o_rec.count     = upd_count;
        o_rec.luhn_zero = (sel_sum == 4'd0);
        o_rec.all_equal = upd_equal;
        o_rec.p1        = upd_lead;
        o_rec.p2        = upd_p2;
        o_rec.p3        = upd_p3;
        o_rec.p4        = upd_p4;
        o_rec.p6        = upd_pfx;
    end

    assign o_push = accept && i_last;

    // Clear the running state once the record has gone
    always_comb begin
        if (o_push) begin
            n_count = 5'd0;
            n_sum_e = 4'd0;
            n_sum_o = 4'd0;
            n_lead  = 4'd0;
            n_equal = 1'b1;
        end else begin
            n_count = upd_count;
            n_sum_e = upd_sum_e;
            n_sum_o = upd_sum_o;
            n_lead  = upd_lead;
            n_equal = upd_equal;
        end
    end

    // Hold control state and the running prefix value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 5'd0;
            r_sum_e <= 4'd0;
            r_sum_o <= 4'd0;
            r_lead  <= 4'd0;
            r_equal <= 1'b1;
            r_pfx   <= 20'd0;
        end else begin
            r_count <= n_count;
            r_sum_e <= n_sum_e;
            r_sum_o <= n_sum_o;
            r_lead  <= n_lead;
            r_equal <= n_equal;
            r_pfx   <= o_push ? 20'd0 : upd_pfx;
        end
    end

    // Short prefix registers; only matter once at least twelve digits have come
    always_ff @(posedge i_clk) begin
        r_p2  <= upd_p2;
        r_p3  <= upd_p3;
        r_p4  <= upd_p4;
    end

endmodule

// ===== hw/rtl/cncb_queue.sv =====
// ----------------------------------------------------------------------------
// cncb_queue
// Short first-in first-out queue of summary records between the front end
// and the back end.
// ----------------------------------------------------------------------------
module cncb_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  cncb_pkg::t_rec    i_rec,
    input  logic              i_pop,
    output cncb_pkg::t_rec    o_head,
    output cncb_pkg::t_q_stat o_stat
);
    import cncb_pkg::*;

    t_rec                r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_W-1:0]  r_cnt,    n_cnt;
    logic                do_push;
    logic                do_pop;

    assign o_stat.full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd_ptr];

    // Advance pointers and the fill count
    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_cnt    = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    // Store the record
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

endmodule

// ===== hw/rtl/cncb_back.sv =====
// ----------------------------------------------------------------------------
// cncb_back
// Takes records from the queue, applies the length, equal-digit and Luhn
// checks and the brand rules, and holds the result in the output register.
// ----------------------------------------------------------------------------
module cncb_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cncb_pkg::t_rec    i_head,
    input  cncb_pkg::t_q_stat i_q_stat,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_number_valid,
    output cncb_pkg::t_brand  o_brand_code,
    output logic [4:0]        o_digits_seen
);
    import cncb_pkg::*;

    logic       r_valid, n_valid;
    logic       r_ok;
    t_brand     r_brand;
    logic [4:0] r_digits;
    logic       chk_ok;
    t_brand     chk_brand;

    // Checks on the head record
    assign chk_ok = (i_head.count >= MIN_LEN) && (i_head.count <= MAX_LEN) &&
                    !i_head.all_equal && i_head.luhn_zero;
    assign chk_brand = brand_of(i_head.count, i_head.p1, i_head.p2,
                                i_head.p3, i_head.p4, i_head.p6);

    // Pop when the output register is free or being emptied
    assign o_pop = !i_q_stat.empty && (!r_valid || i_ready);

    always_comb begin
        n_valid = r_valid;
        if (o_pop) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Load the result
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ok     <= chk_ok;
            r_brand  <= chk_brand;
            r_digits <= i_head.count;
        end
    end

    assign o_valid        = r_valid;
    assign o_number_valid = r_ok;
    assign o_brand_code   = r_brand;
    assign o_digits_seen  = r_digits;

endmodule

// ===== hw/rtl/card_number_check_and_brand_unit.sv =====
// ----------------------------------------------------------------------------
// card_number_check_and_brand_unit
// Checks a card number streamed one character per request (length, digits
// not all equal, Luhn sum) and classifies its brand from prefix and length.
//
//   channel  | dir | tdata                  | tuser                        | tlast
//   ---------+-----+------------------------+------------------------------+------------
//   s_axis   | in  | [7:0] char_in          | -                            | last_char
//   m_axis   | out | [4:0] digits_seen, pad | [0] number_valid, [4:1] brand| -
//
// One character is taken every cycle while the queue is not full. A result
// for the request carrying tlast enters the two-entry queue and is then loaded
// into the output register. Reset clears the running state, the queue and the
// output valid. A stalled output fills the queue; the input stalls only when
// both queue entries hold results not yet taken.
// ----------------------------------------------------------------------------
module card_number_check_and_brand_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] char_in
    input  logic       i_s_axis_tlast,
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [4:0] digits_seen, [7:5] zero
    output logic [4:0] o_m_axis_tuser    // [0] number_valid, [4:1] brand_code
);
    import cncb_pkg::*;

    t_rec       front_rec;
    t_rec       head_rec;
    t_q_stat    q_stat;
    logic       push;
    logic       pop;
    logic       res_ok;
    t_brand     res_brand;
    logic [4:0] res_digits;

    cncb_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_char   (i_s_axis_tdata),
        .i_last   (i_s_axis_tlast),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_rec    (front_rec)
    );

    cncb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (front_rec),
        .i_pop   (pop),
        .o_head  (head_rec),
        .o_stat  (q_stat)
    );

    cncb_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head_rec),
        .i_q_stat       (q_stat),
        .o_pop          (pop),
        .o_valid        (o_m_axis_tvalid),
        .i_ready        (i_m_axis_tready),
        .o_number_valid (res_ok),
        .o_brand_code   (res_brand),
        .o_digits_seen  (res_digits)
    );

    // Pack the result
    assign o_m_axis_tdata = {3'b000, res_digits};
    assign o_m_axis_tuser = {res_brand, res_ok};

endmodule

// ===== hw/rtl/cncb_checker.sv =====
// ----------------------------------------------------------------------------
// cncb_checker
// Port-level checks on the card number check and brand unit, bound to the
// top level.
// ----------------------------------------------------------------------------
module cncb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata,
    input logic [4:0] o_m_axis_tuser
);

    // No result straight after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

    // A passing number has an allowed length
    a_valid_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |->
            o_m_axis_tdata[4:0] >= 5'd13 && o_m_axis_tdata[4:0] <= 5'd19)
        else $error("valid number with bad length");

    // A known brand needs twelve to nineteen digits and a defined code
    a_brand_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[4:1] != 4'd0 |->
            o_m_axis_tdata[4:0] >= 5'd12 && o_m_axis_tdata[4:0] <= 5'd19 &&
            o_m_axis_tuser[4:1] <= 4'd8)
        else $error("brand given for impossible length or code");

endmodule

bind card_number_check_and_brand_unit cncb_checker u_cncb_checker (.*);

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stream-level test of the card number check and brand unit. Card numbers go
// in one character per request, with separators and stray bytes mixed in. A
// local model of the digit count, the two Luhn sums, the lead digit, the
// all-equal flag and the six-digit prefix predicts each verdict, and the
// output stream is checked against it in order. The sender works in bursts,
// the receiver stalls on its own pattern, and a watchdog ends a hung run.
// ----------------------------------------------------------------------------
module tb;

    import cncb_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_CHARS   = 40;
    localparam int HOLD_OFF_LEN   = 80;
    localparam int DRAIN_CYCLES   = 8;

    // Receiver stall patterns
    localparam int RX_FREE   = 0;
    localparam int RX_COIN   = 1;
    localparam int RX_THIRD  = 2;
    localparam int RX_SPARSE = 3;

    typedef struct packed {
        logic       ok;
        t_brand     brand;
        logic [4:0] len;
    } t_card_result;

    logic       i_clk;
    logic       i_rst_n         = 1'b0;
    logic       i_s_axis_tvalid = 1'b0;
    logic       o_s_axis_tready;
    logic [7:0] i_s_axis_tdata  = 8'h00;   // [7:0] char_in
    logic       i_s_axis_tlast  = 1'b0;
    logic       o_m_axis_tvalid;
    logic       i_m_axis_tready = 1'b0;
    logic [7:0] o_m_axis_tdata;            // [4:0] digits_seen, [7:5] zero
    logic [4:0] o_m_axis_tuser;            // [0] number_valid, [4:1] brand_code

    card_number_check_and_brand_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // Running card state of the local model
    logic [4:0]  run_len;
    logic [3:0]  luhn_even;
    logic [3:0]  luhn_odd;
    logic [3:0]  first_digit;
    logic        uniform;
    logic [19:0] head_value;

    t_card_result card_expected[$];
    int unsigned  digit_buf[$];

    int  mismatches    = 0;
    int  chars_sent    = 0;
    int  idle_cycles   = 0;
    int  tx_burst_left = 0;
    bit  tx_pause_req  = 1'b0;
    bit  rx_hold_pending = 1'b0;
    int  rx_hold_left  = 0;
    int  rx_mode       = RX_FREE;
    int  rx_tick       = 0;
    t_card_result rx_want;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Local model
    // ------------------------------------------------------------------------

    // Return the card state to its idle values
    task automatic clear_card_state();
        run_len     = 5'd0;
        luhn_even   = 4'd0;
        luhn_odd    = 4'd0;
        first_digit = 4'd0;
        uniform     = 1'b1;
        head_value  = 20'd0;
    endtask

    // Brand from digit count and prefix, first matching rule wins
    function automatic t_brand brand_for(input logic [4:0] len, input logic [19:0] p6);
        int unsigned n, h1, h2, h3, h4, h6;
        n  = len;
        h6 = p6;
        h1 = h6 / 100000;
        h2 = h6 / 10000;
        h3 = h6 / 1000;
        h4 = h6 / 100;
        if (h1 == 4 && n >= 13 && n <= 16) return BRAND_LEAD4;
        if (n == 16 && ((h2 >= 51 && h2 <= 55) || (h4 >= 2221 && h4 <= 2720)))
            return BRAND_51_55;
        if (n == 15 && (h2 == 34 || h2 == 37)) return BRAND_34_37;
        if (h2 == 62 && n >= 16 && n <= 19) return BRAND_62;
        if (n == 16 && (h4 == 6011 || h2 == 65 || (h6 >= 622126 && h6 <= 622925)))
            return BRAND_6011;
        if (n == 16 && h4 >= 3528 && h4 <= 3589) return BRAND_35;
        if (n == 14 && ((h3 >= 300 && h3 <= 305) || h2 == 36 || h2 == 38 || h2 == 39))
            return BRAND_30_39;
        if (n >= 12 && n <= 19 && (h2 == 50 || (h2 >= 56 && h2 <= 69))) return BRAND_5_6X;
        return BRAND_NONE;
    endfunction

    // Fold one accepted character into the card state; queue a verdict on tlast
    task automatic track_char(input logic [7:0] ch, input logic last);
        logic [3:0]   d;
        logic [3:0]   dd;
        logic [3:0]   sum;
        t_card_result r;
        if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
            d  = 4'(ch - CHAR_ZERO);
            dd = (d > 4'd4) ? 4'(2 * d - 9) : 4'(2 * d);
            if (!run_len[0]) begin
                luhn_even = 4'((luhn_even + dd) % 10);
                luhn_odd  = 4'((luhn_odd + d) % 10);
            end else begin
                luhn_even = 4'((luhn_even + d) % 10);
                luhn_odd  = 4'((luhn_odd + dd) % 10);
            end
            if (run_len == 5'd0)
                first_digit = d;
            else if (d != first_digit)
                uniform = 1'b0;
            if (run_len < 5'd6)
                head_value = 20'(head_value * 10 + d);
            if (run_len != 5'd31)
                run_len = run_len + 5'd1;
        end
        if (last) begin
            sum      = run_len[0] ? luhn_odd : luhn_even;
            r.ok     = (run_len >= 5'd13 && run_len <= 5'd19 && !uniform && sum == 4'd0);
            r.brand  = brand_for(run_len, head_value);
            r.len    = run_len;
            card_expected.push_back(r);
            clear_card_state();
        end
    endtask

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------

    // Offer one character and hold it until accepted; then idle or pause
    task automatic push_char(input logic [7:0] ch, input logic last);
        int gap;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= ch;
        i_s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        track_char(ch, last);
        chars_sent++;
        if (tx_pause_req && last) begin
            // hold the input until every verdict has come back
            tx_pause_req = 1'b0;
            i_s_axis_tvalid <= 1'b0;
            wait (card_expected.size() == 0);
            @(posedge i_clk);
        end else if (tx_burst_left == 0) begin
            tx_burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                       : $urandom_range(1, 12);
            gap = $urandom_range(0, 10);
            if (gap != 0) begin
                i_s_axis_tvalid <= 1'b0;
                i_s_axis_tdata  <= 8'($urandom);
                i_s_axis_tlast  <= 1'($urandom);
                repeat (gap) @(posedge i_clk);
            end
        end else begin
            tx_burst_left--;
        end
    endtask

    // Any byte outside the decimal digit range
    function automatic logic [7:0] junk_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while (c >= CHAR_ZERO && c <= CHAR_NINE);
        return c;
    endfunction

    // Build a digit string: prefix, random fill, optional Luhn check digit
    task automatic compose_card(input int unsigned pfx, input int unsigned pfx_len,
                                input int unsigned total, input bit make_valid);
        int unsigned t, s, d, pos;
        digit_buf.delete();
        t = pfx;
        for (int i = 0; i < pfx_len; i++) begin
            digit_buf.push_front(t % 10);
            t = t / 10;
        end
        while (digit_buf.size() < total) digit_buf.push_back($urandom_range(0, 9));
        while (digit_buf.size() > total) void'(digit_buf.pop_back());
        if (make_valid && total > 0) begin
            digit_buf[total - 1] = 0;
            s = 0;
            for (int i = 0; i < total; i++) begin
                pos = total - 1 - i;
                d   = digit_buf[i];
                if (pos % 2 == 1) d = (d > 4) ? 2 * d - 9 : 2 * d;
                s += d;
            end
            digit_buf[total - 1] = (10 - s % 10) % 10;
        end
    endtask

    // Stream the digit string, optionally with stray bytes and a non-digit end
    task automatic send_card(input bit with_junk, input bit junk_last);
        int n;
        n = digit_buf.size();
        for (int i = 0; i < n; i++) begin
            if (with_junk && $urandom_range(0, 3) == 0) push_char(junk_char(), 1'b0);
            push_char(8'(CHAR_ZERO + digit_buf[i]), (i == n - 1) && !junk_last);
        end
        if (junk_last || n == 0) push_char(junk_char(), 1'b1);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: check each verdict against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (card_expected.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result tdata=%h tuser=%h",
                         $time, o_m_axis_tdata, o_m_axis_tuser);
            end else begin
                rx_want = card_expected.pop_front();
                if (o_m_axis_tuser[0] !== rx_want.ok) begin
                    mismatches++;
                    $display("%0t: number_valid expected %0d actual %0d",
                             $time, rx_want.ok, o_m_axis_tuser[0]);
                end
                if (o_m_axis_tuser[4:1] !== rx_want.brand) begin
                    mismatches++;
                    $display("%0t: brand_code expected %0d actual %0d",
                             $time, rx_want.brand, o_m_axis_tuser[4:1]);
                end
                if (o_m_axis_tdata[4:0] !== rx_want.len) begin
                    mismatches++;
                    $display("%0t: digits_seen expected %0d actual %0d",
                             $time, rx_want.len, o_m_axis_tdata[4:0]);
                end
                if (o_m_axis_tdata[7:5] !== 3'd0) begin
                    mismatches++;
                    $display("%0t: tdata pad expected 0 actual %0d",
                             $time, o_m_axis_tdata[7:5]);
                end
            end
        end

        // pick the next tready: long hold-off first, else the current pattern
        rx_tick++;
        if (rx_tick % 64 == 0) rx_mode = $urandom_range(RX_FREE, RX_SPARSE);
        if (rx_hold_pending) begin
            rx_hold_pending = 1'b0;
            rx_hold_left    = HOLD_OFF_LEN;
        end
        if (rx_hold_left != 0) begin
            rx_hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_FREE:  i_m_axis_tready <= 1'b1;
                RX_COIN:  i_m_axis_tready <= 1'($urandom_range(0, 1));
                RX_THIRD: i_m_axis_tready <= (rx_tick % 3 == 0);
                default:  i_m_axis_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Watchdog: count cycles with no request or result moving
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding",
                     $time, card_expected.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Bytes at and around the digit range, mixed into a valid lead-4 number
    task automatic test_boundary_chars();
        logic [7:0] strays[6] = '{8'h00, 8'hFF, 8'h2F, 8'h3A, 8'h7F, 8'h80};
        compose_card(4, 1, 16, 1'b1);
        for (int i = 0; i < 16; i++) begin
            if (i < 6) push_char(strays[i], 1'b0);
            push_char(8'(CHAR_ZERO + digit_buf[i]), 1'b0);
        end
        push_char(8'h3A, 1'b1);
        push_char(8'h00, 1'b1);
        push_char(8'hFF, 1'b1);
        push_char(8'h39, 1'b1);
        push_char(8'h30, 1'b1);
    endtask

    // One Luhn-valid number for every brand rule and for most of their range edges
    task automatic test_brand_rules();
        int unsigned bp[24] = '{4, 4, 4, 51, 55, 2221, 2720, 34, 37, 62, 62, 6011,
                                65, 622126, 3528, 3589, 300, 305, 36, 38, 39, 50, 69, 1};
        int unsigned bl[24] = '{1, 1, 1, 2, 2, 4, 4, 2, 2, 2, 2, 4,
                                2, 6, 4, 4, 3, 3, 2, 2, 2, 2, 2, 1};
        int unsigned bn[24] = '{13, 16, 17, 16, 16, 16, 16, 15, 15, 16, 19, 16,
                                16, 16, 16, 16, 14, 14, 14, 14, 14, 12, 19, 16};
        for (int i = 0; i < 24; i++) begin
            compose_card(bp[i], bl[i], bn[i], 1'b1);
            send_card(1'b0, 1'b0);
        end
    endtask

    // Empty, repeated-digit, short, long and saturating numbers
    task automatic test_special_lengths();
        int unsigned lens[6] = '{12, 13, 19, 20, 31, 35};
        push_char(8'h20, 1'b1);
        compose_card(0, 0, 13, 1'b0);
        foreach (digit_buf[i]) digit_buf[i] = 0;
        send_card(1'b0, 1'b0);
        compose_card(0, 0, 16, 1'b0);
        foreach (digit_buf[i]) digit_buf[i] = 5;
        send_card(1'b1, 1'b0);
        foreach (lens[i]) begin
            compose_card(4, 1, lens[i], 1'b1);
            send_card(1'b0, 1'b0);
        end
        compose_card(37, 2, 15, 1'b1);
        send_card(1'b1, 1'b1);
    endtask

    // Stall the receiver for a long stretch while short numbers keep coming
    task automatic test_backpressure();
        rx_hold_pending = 1'b1;
        repeat (24) begin
            compose_card($urandom_range(0, 9), 1, $urandom_range(0, 2), 1'b0);
            send_card(1'b0, 1'($urandom_range(0, 1)));
        end
    endtask

    // Pause the sender until every verdict has been taken
    task automatic test_drain_pause();
        tx_pause_req = 1'b1;
        compose_card(5, 1, 16, 1'b1);
        send_card(1'b0, 1'b0);
        compose_card(62, 2, 18, 1'b1);
        send_card(1'b1, 1'b0);
    endtask

    // Mostly well-formed numbers with random content, some noise
    task automatic test_random_cards();
        int          start;
        int unsigned pfx, plen, total, cards;
        start = chars_sent;
        cards = 0;
        while (chars_sent - start < RANDOM_CHARS) begin
            plen = 2;
            case ($urandom_range(0, 12))
                0:  begin pfx = 4; plen = 1; end
                1:  pfx = $urandom_range(51, 55);
                2:  begin pfx = $urandom_range(2220, 2721); plen = 4; end
                3:  pfx = $urandom_range(0, 1) ? 34 : 37;
                4:  pfx = 62;
                5:  begin pfx = $urandom_range(6010, 6012); plen = 4; end
                6:  pfx = 65;
                7:  begin pfx = $urandom_range(622125, 622926); plen = 6; end
                8:  begin pfx = $urandom_range(3527, 3590); plen = 4; end
                9:  begin pfx = $urandom_range(299, 306); plen = 3; end
                10: pfx = $urandom_range(35, 40);
                11: pfx = $urandom_range(0, 1) ? 50 : $urandom_range(49, 70);
                default: begin pfx = $urandom_range(0, 999999); plen = 6; end
            endcase
            if ($urandom_range(0, 9) < 7) begin
                total = $urandom_range(12, 19);
                compose_card(pfx, plen, total, $urandom_range(0, 4) != 0);
                send_card($urandom_range(0, 3) == 0, $urandom_range(0, 7) == 0);
            end else begin
                total = $urandom_range(0, 35);
                compose_card(pfx, plen, total, 1'($urandom_range(0, 1)));
                send_card(1'b1, 1'($urandom_range(0, 1)));
            end
            cards++;
            if (cards % 10 == 0) tx_pause_req = 1'b1;
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        clear_card_state();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_boundary_chars();
        test_brand_rules();
        test_special_lengths();
        test_backpressure();
        test_drain_pause();
        test_random_cards();

        // close with an empty number, then drain and let the pipeline settle
        tx_pause_req = 1'b1;
        push_char(8'h2D, 1'b1);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && card_expected.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
